// ===== hdl/bpa_pkg.sv =====
// types, constants and codes shared by the bitmap page allocator
`timescale 1ns / 1ps
package bpa_pkg;

	localparam int NUM_BLOCKS = 1024;
	localparam int MAX_RUN    = 64;
	localparam int WORD_W     = 32;
	localparam int MAP_WORDS  = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
	localparam int BLK_W      = $clog2(NUM_BLOCKS);
	localparam int WADDR_W    = $clog2(MAP_WORDS);
	localparam int BIT_W      = $clog2(WORD_W);
	localparam int RUN_W      = $clog2(MAX_RUN + 1);

	// field widths of the stream words
	localparam int CMD_W    = 2;
	localparam int INDEX_W  = 10;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;
	localparam int FOUND_W  = 10;
	localparam int USED_W   = 11;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOFIT   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOSPACE = 2'd2;

	typedef struct packed {
		logic             hit;
		logic [BLK_W:0]   start;
		logic [RUN_W-1:0] run_next;
	} scan_res_t;

endpackage

// ===== hdl/bitmap_page_allocator.sv =====
// bitmap page allocator top level: command decode, word scan sequencer, run marking
// alloc: from accept to m_tvalid, one bitmap word is read per cycle over up to 32 words,
//   one evaluation stage behind, then the run is marked one map word at a time, up to 3 words
// free and reserve: the run is marked one map word at a time; rejects go straight to the result
// one command at a time; a new word is taken while the previous result still waits
// reset clears the used map and the used-block counter at once, no clearing pass
`timescale 1ns / 1ps
module bitmap_page_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// command words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // block_index[9:0], block_count[16:10], zero fill
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	// result words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // status[1:0], found_block[11:2], used_count[22:12], zero
);
	import bpa_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_MARK = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]            state_q;
	logic [CMD_W-1:0]      cmd_q;
	logic [COUNT_W-1:0]    cnt_q;

	// used map, one bit per block, and the used-block counter
	logic [WORD_W-1:0]     used_map_q [MAP_WORDS];
	logic [USED_W-1:0]     used_total_q;

	// scan: word address issue, then one evaluation stage
	logic [WADDR_W-1:0]    scan_w_q;
	logic                  scan_on_q;
	logic [WORD_W-1:0]     free_s1;
	logic [WADDR_W-1:0]    w_s1;
	logic                  v_s1;
	logic [RUN_W-1:0]      run_q;
	scan_res_t             scan_res;

	// marking: block pointer and blocks left
	logic [BLK_W:0]        mk_b_q;
	logic [COUNT_W-1:0]    mk_rem_q;

	logic [STATUS_W-1:0]   status_q;
	logic [FOUND_W-1:0]    found_q;
	logic                  m_tvalid_q;
	logic [23:0]           m_tdata_q;

	// decoded command word
	logic [CMD_W-1:0]      in_cmd;
	logic [INDEX_W-1:0]    in_index;
	logic [COUNT_W-1:0]    in_count;
	logic                  s_fire;

	// shared map read port
	logic [WADDR_W-1:0]    map_rd_addr;
	logic [WORD_W-1:0]     map_rd_word;
	logic [WORD_W-1:0]     scan_free;

	// marking datapath
	logic [BIT_W-1:0]      mk_off;
	logic [BIT_W:0]        mk_room;
	logic [COUNT_W-1:0]    mk_k;
	logic [WORD_W:0]       mk_ones;
	logic [WORD_W-1:0]     mk_mask;
	logic [WORD_W-1:0]     mk_word;
	logic [USED_W:0]       up_sum;
	logic [USED_W-1:0]     used_next;
	logic [BLK_W:0]        mk_b_next;
	logic                  mk_last;

	logic                  out_free;
	logic                  out_load;

	assign in_cmd   = s_tuser[CMD_W-1:0];
	assign in_index = s_tdata[INDEX_W-1:0];
	assign in_count = s_tdata[INDEX_W +: COUNT_W];

	assign s_tready = (state_q == S_IDLE);
	assign s_fire   = s_tvalid && s_tready;

	assign map_rd_addr = (state_q == S_MARK) ? mk_b_q[BIT_W +: WADDR_W] : scan_w_q;
	assign map_rd_word = used_map_q[map_rd_addr];

	// block 0 is never handed out, so it always looks used to the scan
	always_comb begin
		scan_free = ~map_rd_word;
		if (scan_w_q == '0) scan_free[0] = 1'b0;
	end

	bpa_scan_eval u_scan_eval (
		.free      (free_s1),
		.word_addr (w_s1),
		.run_in    (run_q),
		.need      (cnt_q),
		.res       (scan_res)
	);

	// blocks of the run that fall in the current map word
	assign mk_off  = mk_b_q[BIT_W-1:0];
	assign mk_room = (BIT_W+1)'(WORD_W) - {1'b0, mk_off};
	assign mk_k    = (mk_rem_q < COUNT_W'(mk_room)) ? mk_rem_q : COUNT_W'(mk_room);
	assign mk_ones = ((WORD_W+1)'(1) << mk_k) - (WORD_W+1)'(1);
	assign mk_mask = mk_ones[WORD_W-1:0] << mk_off;
	assign mk_word = (cmd_q == CMD_FREE) ? (map_rd_word & ~mk_mask)
	                                     : (map_rd_word | mk_mask);

	// counter moves once per block touched, saturating at both ends
	assign up_sum = {1'b0, used_total_q} + (USED_W+1)'(mk_k);
	always_comb begin
		if (cmd_q == CMD_FREE) begin
			used_next = (used_total_q < USED_W'(mk_k)) ? '0
			                                           : (used_total_q - USED_W'(mk_k));
		end else begin
			used_next = (up_sum > (USED_W+1)'(NUM_BLOCKS)) ? USED_W'(NUM_BLOCKS)
			                                               : USED_W'(up_sum);
		end
	end

	assign mk_b_next = mk_b_q + (BLK_W+1)'(mk_k);
	// stop at the end of the run or past the last block
	assign mk_last   = (mk_rem_q == mk_k) || mk_b_next[BLK_W];

	assign out_free = !m_tvalid_q || m_tready;
	assign out_load = (state_q == S_DONE) && out_free;

	// map storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) used_map_q[i] <= '0;
		end else if (state_q == S_MARK) begin
			used_map_q[map_rd_addr] <= mk_word;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			used_total_q <= '0;
			scan_on_q    <= 1'b0;
			v_s1         <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_fire) begin
						if (in_cmd == CMD_ALLOC) begin
							if ((used_total_q >= USED_W'(NUM_BLOCKS)) || (in_count == '0)) begin
								state_q <= S_DONE;
							end else if (in_count > COUNT_W'(MAX_RUN)) begin
								state_q <= S_DONE;
							end else begin
								state_q   <= S_SCAN;
								scan_on_q <= 1'b1;
								v_s1      <= 1'b0;
							end
						end else if ((in_cmd == CMD_FREE) || (in_cmd == CMD_RESERVE)) begin
							if ((in_count > COUNT_W'(MAX_RUN)) || (in_count == '0)) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_MARK;
							end
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (v_s1 && scan_res.hit) begin
						state_q   <= S_MARK;
						scan_on_q <= 1'b0;
						v_s1      <= 1'b0;
					end else if (v_s1 && (w_s1 == WADDR_W'(MAP_WORDS - 1))) begin
						state_q <= S_DONE;
						v_s1    <= 1'b0;
					end else begin
						v_s1 <= scan_on_q;
						if (scan_on_q && (scan_w_q == WADDR_W'(MAP_WORDS - 1))) begin
							scan_on_q <= 1'b0;
						end
					end
				end
				S_MARK: begin
					used_total_q <= used_next;
					if (mk_last) state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command and scan payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q    <= in_cmd;
			cnt_q    <= in_count;
			mk_b_q   <= {1'b0, in_index};
			mk_rem_q <= in_count;
			scan_w_q <= '0;
			run_q    <= '0;
			found_q  <= '0;
			if (in_cmd == CMD_ALLOC) begin
				if ((used_total_q >= USED_W'(NUM_BLOCKS)) || (in_count == '0)) begin
					status_q <= STAT_NOSPACE;
				end else if (in_count > COUNT_W'(MAX_RUN)) begin
					status_q <= STAT_NOFIT;
				end else begin
					status_q <= STAT_OK;
				end
			end else if (((in_cmd == CMD_FREE) || (in_cmd == CMD_RESERVE))
			             && (in_count > COUNT_W'(MAX_RUN))) begin
				status_q <= STAT_NOFIT;
			end else begin
				status_q <= STAT_OK;
			end
		end
		if ((state_q == S_SCAN) && scan_on_q) begin
			free_s1  <= scan_free;
			w_s1     <= scan_w_q;
			scan_w_q <= scan_w_q + WADDR_W'(1);
		end
		if ((state_q == S_SCAN) && v_s1) begin
			if (scan_res.hit) begin
				found_q  <= scan_res.start[FOUND_W-1:0];
				mk_b_q   <= scan_res.start;
				mk_rem_q <= cnt_q;
			end else begin
				run_q <= scan_res.run_next;
				if (w_s1 == WADDR_W'(MAP_WORDS - 1)) status_q <= STAT_NOFIT;
			end
		end
		if (state_q == S_MARK) begin
			mk_b_q   <= mk_b_next;
			mk_rem_q <= mk_rem_q - mk_k;
		end
		if (out_load) begin
			m_tdata_q <= {1'b0, used_total_q, found_q, status_q};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// counter never passes the number of blocks
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_total_q <= USED_W'(NUM_BLOCKS))
		else $error("used-block counter above block count");

	// a marking pass always has blocks left to touch
	a_mark_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK) |-> (mk_rem_q != '0))
		else $error("marking pass with empty run");

	// a successful allocate never reports block 0
	a_alloc_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (cmd_q == CMD_ALLOC) && (status_q == STAT_OK)) |-> (found_q != '0))
		else $error("allocate handed out block 0");

	// a failed command reports no block
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (status_q != STAT_OK)) |-> (found_q == '0))
		else $error("failed command reports a block");

endmodule

// ===== hdl/bpa_scan_eval.sv =====
// first-fit evaluation of one bitmap word against the run carried in from lower words
`timescale 1ns / 1ps
module bpa_scan_eval (
	input  logic [bpa_pkg::WORD_W-1:0]  free,
	input  logic [bpa_pkg::WADDR_W-1:0] word_addr,
	input  logic [bpa_pkg::RUN_W-1:0]   run_in,
	input  logic [bpa_pkg::COUNT_W-1:0] need,
	output bpa_pkg::scan_res_t          res
);
	import bpa_pkg::*;

	logic [BIT_W:0]       trail;
	logic [BIT_W:0]       lead;
	logic                 all_free;
	logic [RUN_W:0]       cross_len;
	logic                 cross_hit;
	logic [WORD_W-1:0]    e2, e4, e8, e16, base, fit;
	logic [3:0]           sh;
	logic [BIT_W-1:0]     fit_pos;
	logic [RUN_W:0]       run_wide;
	logic [BLK_W:0]       word_base;

	// free bits from bit 0 up, and from the top bit down
	always_comb begin
		trail = (BIT_W+1)'(WORD_W);
		lead  = (BIT_W+1)'(WORD_W);
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!free[i]) trail = (BIT_W+1)'(i);
		end
		for (int i = 0; i < WORD_W; i++) begin
			if (!free[i]) lead = (BIT_W+1)'(WORD_W - 1 - i);
		end
	end

	assign all_free  = &free;
	assign cross_len = {1'b0, run_in} + (RUN_W+1)'(trail);
	assign cross_hit = cross_len >= {1'b0, need};

	// erosion: bit i stays set when 2^k free blocks start at i
	assign e2  = free & (free >> 1);
	assign e4  = e2 & (e2 >> 2);
	assign e8  = e4 & (e4 >> 4);
	assign e16 = e8 & (e8 >> 8);

	always_comb begin
		base = free;
		sh   = 4'd0;
		if (need >= 7'd16) begin
			base = e16;
			sh   = 4'(need - 7'd16);
		end else if (need >= 7'd8) begin
			base = e8;
			sh   = 4'(need - 7'd8);
		end else if (need >= 7'd4) begin
			base = e4;
			sh   = 4'(need - 7'd4);
		end else if (need >= 7'd2) begin
			base = e2;
			sh   = 4'(need - 7'd2);
		end
	end

	assign fit = (need < 7'(WORD_W)) ? (base & (base >> sh)) : '0;

	always_comb begin
		fit_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (fit[i]) fit_pos = BIT_W'(i);
		end
	end

	assign word_base = {1'b0, word_addr, {BIT_W{1'b0}}};
	assign run_wide  = {1'b0, run_in} + (RUN_W+1)'(WORD_W);

	always_comb begin
		res.hit      = cross_hit || (fit != '0);
		// a run reaching in from lower words starts earlier than any inside this word
		res.start    = cross_hit ? (word_base - (BLK_W+1)'(run_in))
		                         : {1'b0, word_addr, fit_pos};
		if (all_free) begin
			res.run_next = (run_wide > (RUN_W+1)'(MAX_RUN)) ? RUN_W'(MAX_RUN)
			                                                : RUN_W'(run_wide);
		end else begin
			res.run_next = RUN_W'(lead);
		end
	end

endmodule

// ===== verif/bpa_checker.sv =====
// reply checker for the bitmap page allocator: mirrors the used map and compares each reply word
`timescale 1ns / 1ps
module bpa_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // block_index[9:0], block_count[16:10], zero fill
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // status[1:0], found_block[11:2], used_count[22:12], zero
	output int          errors,
	output int          awaited,
	output int          checked,
	output int          granted
);
	import bpa_pkg::*;

	// members listed from the top bit down, so status lands in the low bits
	typedef struct packed {
		logic [USED_W-1:0]   used_count;
		logic [FOUND_W-1:0]  found_block;
		logic [STATUS_W-1:0] status;
	} reply_t;

	logic [NUM_BLOCKS-1:0] map_bits;
	int unsigned           used_tally;
	reply_t                awaited_replies[$];

	// one block touched: the counter moves even when the bit already had that value
	task automatic mark_block(input int unsigned blk, input logic set);
		map_bits[blk] = set;
		if (set) begin
			if (used_tally < NUM_BLOCKS)
				used_tally++;
		end else if (used_tally > 0) begin
			used_tally--;
		end
	endtask

	task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
			input logic [COUNT_W-1:0] cnt, output reply_t r);
		int unsigned run;
		int unsigned start;
		int unsigned b;
		r.status      = STAT_OK;
		r.found_block = '0;
		if (cmd == CMD_ALLOC) begin
			if (used_tally >= NUM_BLOCKS || cnt == 0) begin
				r.status = STAT_NOSPACE;
			end else if (cnt > MAX_RUN) begin
				r.status = STAT_NOFIT;
			end else begin
				// first free run that ends is also the lowest start; block 0 never counts
				start = 0;
				run   = 0;
				for (b = 1; b < NUM_BLOCKS && start == 0; b++) begin
					run = map_bits[b] ? 0 : run + 1;
					if (run == cnt)
						start = b - cnt + 1;
				end
				if (start == 0) begin
					r.status = STAT_NOFIT;
				end else begin
					for (b = start; b < start + cnt; b++)
						mark_block(b, 1'b1);
					r.found_block = start[FOUND_W-1:0];
				end
			end
		end else if (cmd == CMD_FREE || cmd == CMD_RESERVE) begin
			if (cnt > MAX_RUN) begin
				r.status = STAT_NOFIT;
			end else begin
				for (b = idx; b < idx + cnt; b++)
					if (b < NUM_BLOCKS)
						mark_block(b, cmd == CMD_RESERVE);
			end
		end
		r.used_count = used_tally[USED_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			map_bits   = '0;
			used_tally = 0;
			awaited_replies.delete();
			errors  = 0;
			checked = 0;
			granted = 0;
			awaited = 0;
		end else begin
			// reply side first, so a word taken at the same edge queues behind
			if (m_tvalid && m_tready) begin
				got = reply_t'(m_tdata[USED_W+FOUND_W+STATUS_W-1:0]);
				if (awaited_replies.size() == 0) begin
					$error("reply word %h with no command outstanding", m_tdata);
					errors++;
				end else begin
					want = awaited_replies.pop_front();
					checked++;
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						errors++;
					end
					if (got.found_block !== want.found_block) begin
						$error("found_block: expected %0d, actual %0d",
							want.found_block, got.found_block);
						errors++;
					end
					if (got.used_count !== want.used_count) begin
						$error("used_count: expected %0d, actual %0d",
							want.used_count, got.used_count);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				apply_command(s_tuser, s_tdata[INDEX_W-1:0],
					s_tdata[INDEX_W+COUNT_W-1:INDEX_W], want);
				if (want.found_block != 0)
					granted++;
				awaited_replies.push_back(want);
			end
			awaited = awaited_replies.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// testbench top for the bitmap page allocator: command stimulus, traffic phases and verdict
`timescale 1ns / 1ps
module tb;
	import bpa_pkg::*;

	// the one code the package leaves unassigned, has to behave as a no-op
	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	localparam int RANDOM_PER_PHASE = 262;   // four phases, about 1050 random words
	localparam int WATCHDOG_CYCLES  = 4000;  // far above alloc latency plus any stall
	localparam int DRAIN_CYCLES     = 60;    // longer than the slowest alloc
	localparam int PAD_W            = 24 - INDEX_W - COUNT_W;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // block_index[9:0], block_count[16:10], zero fill
	logic [1:0]  s_tuser  = '0;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;         // status[1:0], found_block[11:2], used_count[22:12], zero

	int idle_pct    = 0;   // chance per cycle that the sender holds back
	int stall_pct   = 0;   // chance per cycle that the receiver is not ready
	int sent        = 0;
	int quiet_cycles = 0;
	int errors;
	int awaited;
	int checked;
	int granted;

	bitmap_page_allocator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bpa_checker replies (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.awaited  (awaited),
		.checked  (checked),
		.granted  (granted)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver back-pressure, one decision per cycle at the falling edge
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// watchdog: too long without any word moving on either side means a hang
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// one command word: random hold-off, then hold valid until the block takes it
	// valid stays high into the next call unless that call idles first
	task automatic send_word(input logic [CMD_W-1:0] cmd, input int idx, input int cnt);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tuser  <= cmd;
		s_tdata  <= {{PAD_W{1'b0}}, COUNT_W'(cnt), INDEX_W'(idx)};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
	endtask

	initial begin : stimulus
		logic [CMD_W-1:0] all_ops [4];
		logic [CMD_W-1:0] op;
		int               pick;
		int               cnt;
		int               idx;
		int               n;
		bit               draining;

		all_ops = '{CMD_ALLOC, CMD_FREE, CMD_RESERVE, CMD_NONE};

		// single reset pulse at the start
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words, no idling on either side
		send_word(CMD_ALLOC, 0, 0);            // zero count allocate is refused
		send_word(CMD_ALLOC, 0, 65);           // one past the longest run
		send_word(CMD_ALLOC, 0, 1);            // first grant must skip block 0
		send_word(CMD_ALLOC, 0, MAX_RUN);      // longest run right behind it
		send_word(CMD_FREE, 1, 1);
		send_word(CMD_ALLOC, 0, 1);            // hole at block 1 is reused
		send_word(CMD_FREE, 5, 0);             // zero count free does nothing
		send_word(CMD_RESERVE, 1023, 127);     // all ones count, rejected as too long
		send_word(CMD_NONE, 1023, 127);        // unassigned code with all fields high
		send_word(CMD_RESERVE, 1000, MAX_RUN); // run clipped at the last block
		send_word(CMD_FREE, 0, MAX_RUN);
		send_word(CMD_FREE, 960, MAX_RUN);     // counter bottoms out at zero
		// fill the whole map, block 0 included, counter pins at the top
		for (n = 0; n < NUM_BLOCKS / MAX_RUN; n++)
			send_word(CMD_RESERVE, n * MAX_RUN, MAX_RUN);
		send_word(CMD_ALLOC, 0, 1);            // full map refused
		send_word(CMD_FREE, 512, 2);
		send_word(CMD_ALLOC, 0, 3);            // two-block hole is too short
		send_word(CMD_ALLOC, 0, 2);            // exact fit in the hole
		send_word(CMD_FREE, 960, MAX_RUN);
		send_word(CMD_ALLOC, 0, MAX_RUN);      // run ending on the last block

		// random words over four traffic mixes
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 83; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 83; end
				default: begin idle_pct = 35; stall_pct = 35; end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				// mostly filling epochs, every third one drains the map again
				draining = ((n / 64) % 3) == 2;
				pick = $urandom_range(99);
				cnt  = $urandom_range(99);
				if (cnt < 70)
					cnt = $urandom_range(1, 8);
				else if (cnt < 92)
					cnt = $urandom_range(9, 40);
				else
					cnt = $urandom_range(41, MAX_RUN);
				// allocations sit low in the map, so frees lean that way too
				idx = $urandom_range(1) ? $urandom_range(0, 1023) : $urandom_range(0, 300);
				if (pick < (draining ? 20 : 72)) begin
					op  = CMD_ALLOC;
				end else if (pick < (draining ? 30 : 82)) begin
					op  = CMD_RESERVE;
				end else if (pick < (draining ? 90 : 95)) begin
					op  = CMD_FREE;
				end else begin
					// noise: oversize runs, zero counts, unassigned code, runs off the end
					case ($urandom_range(3))
						0: begin
							op  = all_ops[$urandom_range(0, 3)];
							cnt = $urandom_range(65, 127);
						end
						1: begin
							op  = all_ops[$urandom_range(0, 2)];
							cnt = 0;
						end
						2: begin
							op  = CMD_NONE;
							cnt = $urandom_range(0, 127);
						end
						default: begin
							op  = all_ops[$urandom_range(1, 2)];
							idx = $urandom_range(960, 1023);
						end
					endcase
				end
				send_word(op, idx, cnt);
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		// the watchdog covers a reply that never shows up
		while (awaited != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d command words: directed corners, then free flow, sparse sender,",
			sent);
		$display("slow receiver and mixed traffic; %0d replies compared, %0d runs granted",
			checked, granted);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
